// File: sv/fta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fta_pkg
// shared types and constants of the truncating single-precision adder
// ----------------------------------------------------------------------------
package fta_pkg;
   localparam int unsigned FracBits = 23;
   localparam logic [31:0] HiddenOne = 32'h0080_0000;
   localparam logic [31:0] FracMask = 32'h007F_FFFF;

   typedef struct packed {
      logic [31:0] operand_a;
      logic [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [31:0] sum_bits;
   } rsp_type;
endpackage

// File: sv/fta_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fta_if
// valid/ready channel carrying one payload beat
// ----------------------------------------------------------------------------
interface fta_req_if;
   logic valid;
   logic ready;
   fta_pkg::req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface fta_rsp_if;
   logic valid;
   logic ready;
   fta_pkg::rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// File: sv/fta_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fta_datapath
// align, add, normalize and pack one pair of operands
// ----------------------------------------------------------------------------
module fta_datapath (
   input  fta_pkg::req_type operands,
   output fta_pkg::rsp_type result
);
   import fta_pkg::*;

   logic [7:0]  ea, eb, emax, shamt;
   logic [31:0] ma, mb, small_m, big_m, shifted, sum, mag, norm;
   logic        a_larger, sign;
   logic [4:0]  lead;
   logic [7:0]  exp_out;

   always_comb begin
      ea = operands.operand_a[30:23];
      eb = operands.operand_b[30:23];
      ma = (operands.operand_a & FracMask) | HiddenOne;
      if (operands.operand_a[31]) ma = 32'd0 - ma;
      mb = (operands.operand_b & FracMask) | HiddenOne;
      if (operands.operand_b[31]) mb = 32'd0 - mb;
      a_larger = ea > eb;
      emax = a_larger ? ea : eb;
      shamt = a_larger ? (ea - eb) : (eb - ea);
      small_m = a_larger ? mb : ma;
      big_m = a_larger ? ma : mb;
      if (shamt >= 8'd31) shifted = {32{small_m[31]}};
      else shifted = $signed(small_m) >>> shamt[4:0];
      sum = big_m + shifted;
      sign = sum[31];
      mag = sign ? (32'd0 - sum) : sum;
      lead = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (mag[i]) lead = 5'(i);
      end
      if (lead < 5'd23) begin
         norm = mag << (5'd23 - lead);
         exp_out = emax - {3'd0, 5'd23 - lead};
      end else begin
         norm = mag >> (lead - 5'd23);
         exp_out = emax + {3'd0, lead - 5'd23};
      end
      if (sum == 32'd0) result.sum_bits = 32'd0;
      else result.sum_bits = {sign, exp_out, norm[22:0]};
   end
endmodule

// File: sv/float32_truncating_adder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float32_truncating_adder_core
// single-precision adder without rounding or special-value handling
// ----------------------------------------------------------------------------
// req carries a beat of two operand bit patterns, rsp one sum bit pattern.
// a beat is taken into the input register when req valid and ready are high;
// the sum is computed in one pass and loaded into the output register when
// that register is empty or being read, which raises rsp valid.
// throughput is one beat per cycle unless rsp stalls, set by the single-pass datapath.
// when the receiver stalls, the output register holds and the input register
// still takes one more beat; req ready drops only when both are full.
// reset clears both valid flags; payload is not reset.
// ----------------------------------------------------------------------------
module float32_truncating_adder_core (
   input logic clock,
   input logic reset,
   fta_req_if.sink   req,
   fta_rsp_if.source rsp
);
   import fta_pkg::*;

   req_type in_ff, in_in;
   logic    in_vld_ff, in_vld_in;
   rsp_type out_ff, out_in, calc;
   logic    out_vld_ff, out_vld_in;
   logic    advance;

   fta_datapath u_dp (.operands(in_ff), .result(calc));

   assign advance = in_vld_ff && (!out_vld_ff || rsp.ready);
   assign req.ready = !in_vld_ff || advance;
   assign rsp.valid = out_vld_ff;
   assign rsp.payload = out_ff;

   always_comb begin
      in_in = req.valid && req.ready ? req.payload : in_ff;
      in_vld_in = req.ready ? req.valid : in_vld_ff;
      out_in = advance ? calc : out_ff;
      out_vld_in = advance ? 1'b1 : (out_vld_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
      out_ff <= out_in;
      if (reset) begin
         in_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && !rsp.ready |=> out_vld_ff && $stable(out_ff))
      else $error("stalled result changed");
   a_adv: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_vld_ff && out_ff == $past(calc))
      else $error("result not loaded");
   a_full: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> in_vld_ff && out_vld_ff && !rsp.ready)
      else $error("ready low without backpressure");
endmodule

// File: bench/fta_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fta_checker
// predicts every sum of the truncating adder and compares it to the rsp beats
// ----------------------------------------------------------------------------
// watches the req and rsp channels at the rising clock edge; each accepted req
// beat queues its predicted sum, each accepted rsp beat is compared with the
// oldest queued sum. unexpected beats and wrong sums are counted as errors.
// ----------------------------------------------------------------------------
module fta_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  fta_pkg::req_type req_payload,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  fta_pkg::rsp_type rsp_payload,
   output int          error_count,
   output int          pending_count,
   output int          sum_count
);
   import fta_pkg::*;

   logic [31:0] expected_sums[$];

   function automatic logic [31:0] significand(input logic [31:0] bits);
      logic [31:0] m;
      m = (bits & FracMask) | HiddenOne;
      if (bits[31]) begin
         m = -m;
      end
      return m;
   endfunction

   function automatic logic [31:0] align(input logic [31:0] v, input logic [31:0] s);
      if (s >= 31) begin
         return v[31] ? 32'hFFFF_FFFF : 32'h0;
      end
      return $signed(v) >>> s[4:0];
   endfunction

   function automatic logic [31:0] truncated_sum(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] ea, eb, ma, mb, emax, total, mag, expo;
      int lead;
      ea = {24'h0, a[30:23]};
      eb = {24'h0, b[30:23]};
      ma = significand(a);
      mb = significand(b);
      if (ea > eb) begin
         mb = align(mb, ea - eb);
         emax = ea;
      end else begin
         ma = align(ma, eb - ea);
         emax = eb;
      end
      total = ma + mb;
      if (total == 0) begin
         return 32'h0;
      end
      mag = total[31] ? -total : total;
      lead = 0;
      for (int i = 31; i >= 0; i--) begin
         if (mag[i]) begin
            lead = i;
            break;
         end
      end
      if (lead < FracBits) begin
         mag = mag << (FracBits - lead);
         expo = emax - (FracBits - lead);
      end else begin
         mag = mag >> (lead - FracBits);
         expo = emax + (lead - FracBits);
      end
      return {total[31], expo[7:0], mag[22:0]};
   endfunction

   assign pending_count = expected_sums.size();

   always @(posedge clock) begin
      if (reset) begin
         error_count <= 0;
         sum_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_sums.push_back(truncated_sum(req_payload.operand_a, req_payload.operand_b));
         end
         if (rsp_valid && rsp_ready) begin
            sum_count <= sum_count + 1;
            if (expected_sums.size() == 0) begin
               $display("%0t: unexpected rsp beat, actual %h", $time, rsp_payload.sum_bits);
               error_count <= error_count + 1;
            end else begin
               if (rsp_payload.sum_bits !== expected_sums[0]) begin
                  $display("%0t: sum_bits mismatch, expected %h actual %h",
                           $time, expected_sums[0], rsp_payload.sum_bits);
                  error_count <= error_count + 1;
               end
               void'(expected_sums.pop_front());
            end
         end
      end
   end
endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the truncating single-precision adder
// ----------------------------------------------------------------------------
// drives directed operand pairs (zeros, cancellation, extreme exponents,
// large alignment, nan and denormal patterns) and then random pairs biased
// toward close exponents, with bursty req traffic and a stalling receiver.
// ----------------------------------------------------------------------------
module tb;
   import fta_pkg::*;

   localparam int RandomBeats = 1500;
   localparam int CycleLimit = 200000;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   error_count;
   int   pending_count;
   int   sum_count;
   int   sent_count;

   fta_req_if req ();
   fta_rsp_if rsp ();

   float32_truncating_adder_core dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   fta_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req.valid),
      .req_ready(req.ready),
      .req_payload(req.payload),
      .rsp_valid(rsp.valid),
      .rsp_ready(rsp.ready),
      .rsp_payload(rsp.payload),
      .error_count(error_count),
      .pending_count(pending_count),
      .sum_count(sum_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb NOT OK");
         $finish;
      end
   end

   // receiver stall pattern: runs of ready and stalls of random length
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else begin
         rsp.ready <= ~rsp.ready;
         stall_left <= rsp.ready ? $urandom_range(0, 4) : $urandom_range(0, 20);
      end
   end

   logic [31:0] directed_a[$];
   logic [31:0] directed_b[$];

   function automatic logic [31:0] random_operand(input logic [7:0] near_exp);
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: v[30:23] = near_exp + 8'($urandom_range(0, 6)) - 8'd3;
         6: v[30:23] = 8'($urandom_range(0, 40)) + near_exp;
         default: ;
      endcase
      return v;
   endfunction

   task automatic send_beat(input logic [31:0] a, input logic [31:0] b);
      req.valid <= 1'b1;
      req.payload.operand_a <= a;
      req.payload.operand_b <= b;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic idle_cycles(input int n);
      req.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   initial begin
      logic [31:0] a, b;
      int burst;
      sent_count = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.payload = '0;
      directed_a = '{32'h0000_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h7F7F_FFFF,
                     32'hFF80_0000, 32'h7FC0_0001, 32'h0000_0001, 32'h4B00_0000,
                     32'h3F80_0000, 32'h8000_0000, 32'h4000_0000, 32'h0080_0000,
                     32'hFFFF_FFFF, 32'h7F80_0000, 32'h3FFF_FFFF, 32'hC0A0_0000};
      directed_b = '{32'h0000_0000, 32'hBF80_0000, 32'h3F80_0000, 32'h7F7F_FFFF,
                     32'hFF80_0000, 32'h0000_0000, 32'h8000_0001, 32'h3F80_0000,
                     32'h4F80_0000, 32'h0000_0000, 32'hC07F_FFFF, 32'h8080_0001,
                     32'h7FFF_FFFF, 32'h0080_0000, 32'h3FFF_FFFF, 32'h40A0_0001};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < directed_a.size(); i++) begin
         send_beat(directed_a[i], directed_b[i]);
      end
      // hold off until every sum has come back
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      while (sent_count < directed_a.size() + RandomBeats) begin
         burst = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
         for (int k = 0; k < burst; k++) begin
            a = $urandom;
            b = random_operand(a[30:23]);
            if ($urandom_range(0, 7) == 0) begin
               b = {~a[31], a[30:0]};
            end
            send_beat(a, b);
         end
         if ($urandom_range(0, 3) != 0) begin
            idle_cycles($urandom_range(1, 8));
         end
      end
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("sent %0d operand pairs (directed edge cases and random near-exponent pairs),",
               sent_count);
      $display("checked %0d sums under bursty input and stalling output", sum_count);
      if (error_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule

// File: filelist.f
sv/fta_pkg.sv
sv/fta_if.sv
sv/fta_datapath.sv
sv/float32_truncating_adder_core.sv
bench/fta_checker.sv
bench/tb.sv
